/* rtl/core/rgst_pkg.sv */
// Shared types, constants and register codes for the ray generate and sphere test core.
package rgst_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int LANE_W          = 16;
    localparam int MAG_W           = 50;
    localparam int NM_W            = 31;
    localparam int QUEUE_DEPTH     = 4;
    localparam int ADDR_W          = 6;
    localparam int APB_DATA_W      = 64;

    typedef enum logic [2:0] {
        REG_BASIS_X   = 3'd0,
        REG_BASIS_Y   = 3'd1,
        REG_BASIS_Z   = 3'd2,
        REG_DET_OFS   = 3'd3,
        REG_AP_OFS    = 3'd4,
        REG_RADIUS    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [47:0]        basis_x;
        logic [47:0]        basis_y;
        logic [47:0]        basis_z;
        logic signed [31:0] detector_offset;
        logic signed [31:0] aperture_offset;
        logic [30:0]        sphere_radius;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] launch;
        logic [2:0][31:0] dir;
        logic [2:0]       sign;
        logic             degen;
    } side_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]      orv;
        side_t                 side;
    } item_t;

    function automatic logic signed [LANE_W-1:0] lane(input logic [47:0] r, input int i);
        return $signed(r[LANE_W*i +: LANE_W]);
    endfunction

endpackage

/* rtl/core/rgst_regs.sv */
// APB configuration register bank.
module rgst_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgst_pkg::ADDR_W-1:0]         paddr,
    input  logic [rgst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rgst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output rgst_pkg::cfg_t                      cfg
);

    rgst_pkg::cfg_t     cfg_reg;
    rgst_pkg::reg_idx_t idx;
    logic               wr;

    assign idx    = rgst_pkg::reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.basis_x         <= 48'd16384;
            cfg_reg.basis_y         <= 48'd1073741824;
            cfg_reg.basis_z         <= 48'd70368744177664;
            cfg_reg.detector_offset <= '0;
            cfg_reg.aperture_offset <= '0;
            cfg_reg.sphere_radius   <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                rgst_pkg::REG_BASIS_X: cfg_reg.basis_x         <= pwdata[47:0];
                rgst_pkg::REG_BASIS_Y: cfg_reg.basis_y         <= pwdata[47:0];
                rgst_pkg::REG_BASIS_Z: cfg_reg.basis_z         <= pwdata[47:0];
                rgst_pkg::REG_DET_OFS: cfg_reg.detector_offset <= pwdata[31:0];
                rgst_pkg::REG_AP_OFS:  cfg_reg.aperture_offset <= pwdata[31:0];
                rgst_pkg::REG_RADIUS:  cfg_reg.sphere_radius   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            rgst_pkg::REG_BASIS_X: prdata = {16'd0, cfg_reg.basis_x};
            rgst_pkg::REG_BASIS_Y: prdata = {16'd0, cfg_reg.basis_y};
            rgst_pkg::REG_BASIS_Z: prdata = {16'd0, cfg_reg.basis_z};
            rgst_pkg::REG_DET_OFS: prdata = {32'd0, cfg_reg.detector_offset};
            rgst_pkg::REG_AP_OFS:  prdata = {32'd0, cfg_reg.aperture_offset};
            rgst_pkg::REG_RADIUS:  prdata = {33'd0, cfg_reg.sphere_radius};
            default:               prdata = '0;
        endcase
    end

endmodule

/* rtl/core/rgst_front.sv */
// Front pipeline: maps both points to 3D, rounds and saturates the launch point, forms the difference.
module rgst_front
#(
    parameter int COORD_WIDTH = rgst_pkg::COORD_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rgst_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [127:0]     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgst_pkg::item_t  out_item
);

    localparam int SW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [rgst_pkg::MAG_W-1:0] LMAX =
        (50'sd1 <<< (SW - 1)) - 50'sd1;
    localparam logic signed [rgst_pkg::MAG_W-1:0] LMIN = -LMAX - 50'sd1;

    logic [3:0]                          v_reg;
    logic                                en;
    logic signed [47:0]                  pb_reg [0:2][0:2];
    logic signed [47:0]                  pt_reg [0:2][0:2];
    logic signed [rgst_pkg::MAG_W-1:0]   base_reg [0:2];
    logic signed [rgst_pkg::MAG_W-1:0]   tgt_reg [0:2];
    logic signed [rgst_pkg::MAG_W-1:0]   d_reg [0:2];
    logic [2:0][31:0]                    lch_reg;
    rgst_pkg::item_t                     item_reg;
    rgst_pkg::item_t                     item_next;
    logic signed [31:0]                  pu, pv, au, av;

    assign pu = in_data[31:0];
    assign pv = in_data[63:32];
    assign au = in_data[95:64];
    assign av = in_data[127:96];

    assign en        = !v_reg[3] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[3];
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        item_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            item_next.mag[i]       = d_reg[i][rgst_pkg::MAG_W-1] ?
                                     rgst_pkg::MAG_W'(-d_reg[i]) : rgst_pkg::MAG_W'(d_reg[i]);
            item_next.side.sign[i] = d_reg[i][rgst_pkg::MAG_W-1];
        end
        item_next.orv         = item_next.mag[0] | item_next.mag[1] | item_next.mag[2];
        item_next.side.launch = lch_reg;
        item_next.side.dir    = '0;
        item_next.side.degen  = (item_next.orv == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [rgst_pkg::MAG_W-1:0] r;
                r = (base_reg[i] + 50'sd8192) >>> 14;
                pb_reg[i][0] <= rgst_pkg::lane(cfg.basis_z, i) * cfg.detector_offset;
                pb_reg[i][1] <= rgst_pkg::lane(cfg.basis_x, i) * pu;
                pb_reg[i][2] <= rgst_pkg::lane(cfg.basis_y, i) * pv;
                pt_reg[i][0] <= rgst_pkg::lane(cfg.basis_z, i) * cfg.aperture_offset;
                pt_reg[i][1] <= rgst_pkg::lane(cfg.basis_x, i) * au;
                pt_reg[i][2] <= rgst_pkg::lane(cfg.basis_y, i) * av;
                base_reg[i]  <= pb_reg[i][0] + pb_reg[i][1] + pb_reg[i][2];
                tgt_reg[i]   <= pt_reg[i][0] + pt_reg[i][1] + pt_reg[i][2];
                d_reg[i]     <= tgt_reg[i] - base_reg[i];
                if (r > LMAX)
                begin
                    lch_reg[i] <= LMAX[31:0];
                end
                else if (r < LMIN)
                begin
                    lch_reg[i] <= LMIN[31:0];
                end
                else
                begin
                    lch_reg[i] <= r[31:0];
                end
            end
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/core/rgst_queue.sv */
// Short request queue between the front and back pipelines.
module rgst_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rgst_pkg::item_t  push_item,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output rgst_pkg::item_t  head
);

    localparam int PW = $clog2(rgst_pkg::QUEUE_DEPTH);

    rgst_pkg::item_t mem_reg [0:rgst_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;

    assign not_full  = (cnt_reg != (PW+1)'(rgst_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/rgst_back.sv */
// Back pipeline: normalize, square root, per-lane division and sphere hit test.
module rgst_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [30:0]      sphere_radius,
    input  logic             q_valid,
    input  rgst_pkg::item_t  q_head,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [191:0]     m_axis_tdata,
    output logic [1:0]       m_axis_tuser
);

    localparam int MW    = rgst_pkg::MAG_W;
    localparam int NW    = rgst_pkg::NM_W;
    localparam int SHW   = $clog2(MW);
    localparam int RT_N  = 32;
    localparam int DV_N  = 31;
    localparam int S_SH  = 1;
    localparam int S_NM  = S_SH + 1;
    localparam int S_SQ  = S_NM + 1;
    localparam int S_SUM = S_SQ + 1;
    localparam int S_NUM = S_SUM + RT_N + 1;
    localparam int S_U   = S_NUM + DV_N + 1;
    localparam int S_P   = S_U + 1;
    localparam int S_C   = S_P + 1;
    localparam int S_PP  = S_C + 1;
    localparam int S_W   = S_PP + 1;
    localparam int S_OUT = S_W + 1;

    logic                  en;
    logic [S_OUT:0]        vld_reg;
    rgst_pkg::side_t       side_reg [0:S_OUT];
    rgst_pkg::side_t       side_u;
    logic [2:0][31:0]      u_next;

    logic [2:0][MW-1:0]    mag0_reg, mag1_reg;
    logic [MW-1:0]         orv0_reg;
    logic [SHW-1:0]        shamt_reg, msb;
    logic [2:0][NW-1:0]    nm2_reg, nm3_reg, nm4_reg;
    logic [2:0][61:0]      sq3_reg;
    logic [63:0]           ss_reg;
    logic [63:0]           rx_reg [0:RT_N-1];
    logic [63:0]           rr_reg [0:RT_N-1];
    logic [2:0][NW-1:0]    nmr_reg [0:RT_N-1];
    logic [2:0][61:0]      num_reg;
    logic [31:0]           dn_reg;
    logic [2:0][61:0]      rem_reg [0:DV_N-1];
    logic [2:0][NW-1:0]    qt_reg [0:DV_N-1];
    logic [31:0]           dv_reg [0:DV_N-1];
    logic signed [63:0]    pr_reg [0:2][0:1];
    logic [2:0][61:0]      usq_reg;
    logic [2:0][63:0]      ca_reg;
    logic [63:0]           uu_reg;
    logic [61:0]           r2_reg;
    logic [2:0][63:0]      pll_reg;
    logic [2:0][62:0]      plm_reg;
    logic [2:0][61:0]      phh_reg;
    logic [63:0]           q00_reg, q01_reg;
    logic [61:0]           q10_reg, q11_reg;
    logic [2:0][127:0]     csq_reg;
    logic [127:0]          rhs_reg;
    logic                  hit_reg;

    assign en    = !vld_reg[S_OUT] || m_axis_tready;
    assign q_pop = en && q_valid;

    assign m_axis_tvalid = vld_reg[S_OUT];
    assign m_axis_tdata  = {side_reg[S_OUT].launch, side_reg[S_OUT].dir};
    assign m_axis_tuser  = {side_reg[S_OUT].degen, hit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[S_OUT-1:0], q_valid};
        end
    end

    always_comb
    begin
        msb = '0;
        for (int b = 0; b < MW; b++)
        begin
            if (orv0_reg[b])
            begin
                msb = SHW'(b);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [31:0] q;
            q = {1'b0, qt_reg[DV_N-1][i]};
            if (side_reg[S_U-1].degen)
            begin
                u_next[i] = '0;
            end
            else if (side_reg[S_U-1].sign[i])
            begin
                u_next[i] = -q;
            end
            else
            begin
                u_next[i] = q;
            end
        end
        side_u     = side_reg[S_U-1];
        side_u.dir = u_next;
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= sphere_radius * sphere_radius;
        if (en)
        begin
            side_reg[0] <= q_head.side;
            for (int k = 1; k <= S_OUT; k++)
            begin
                if (k == S_U)
                begin
                    side_reg[k] <= side_u;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end

            mag0_reg  <= q_head.mag;
            orv0_reg  <= q_head.orv;
            mag1_reg  <= mag0_reg;
            shamt_reg <= SHW'(MW - 1) - msb;
            for (int i = 0; i < 3; i++)
            begin
                logic [MW-1:0] t;
                t          = mag1_reg[i] << shamt_reg;
                nm2_reg[i] <= t[MW-1 -: NW];
                sq3_reg[i] <= nm2_reg[i] * nm2_reg[i];
            end
            nm3_reg <= nm2_reg;
            nm4_reg <= nm3_reg;
            ss_reg  <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
        end
    end

    for (genvar g = 0; g < RT_N; g++)
    begin : g_rt
        localparam logic [63:0] ONE = 64'd1 << (62 - 2 * g);
        logic [63:0]        xi, ri;
        logic [2:0][NW-1:0] ni;
        if (g == 0)
        begin : g_first
            assign xi = ss_reg;
            assign ri = '0;
            assign ni = nm4_reg;
        end
        else
        begin : g_rest
            assign xi = rx_reg[g-1];
            assign ri = rr_reg[g-1];
            assign ni = nmr_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nmr_reg[g] <= ni;
                if (xi >= ri + ONE)
                begin
                    rx_reg[g] <= xi - (ri + ONE);
                    rr_reg[g] <= (ri >> 1) + ONE;
                end
                else
                begin
                    rx_reg[g] <= xi;
                    rr_reg[g] <= ri >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg <= rr_reg[RT_N-1][31:0];
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= {nmr_reg[RT_N-1][i], 30'd0} + 62'(rr_reg[RT_N-1][31:1]);
            end
        end
    end

    for (genvar g = 0; g < DV_N; g++)
    begin : g_dv
        localparam int K = DV_N - 1 - g;
        logic [2:0][61:0]   remi;
        logic [2:0][NW-1:0] qi;
        logic [31:0]        di;
        logic [61:0]        dsh;
        if (g == 0)
        begin : g_first
            assign remi = num_reg;
            assign qi   = '0;
            assign di   = dn_reg;
        end
        else
        begin : g_rest
            assign remi = rem_reg[g-1];
            assign qi   = qt_reg[g-1];
            assign di   = dv_reg[g-1];
        end
        assign dsh = 62'(di) << K;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[g] <= di;
                for (int i = 0; i < 3; i++)
                begin
                    if (remi[i] >= dsh)
                    begin
                        rem_reg[g][i] <= remi[i] - dsh;
                        qt_reg[g][i]  <= {qi[i][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[g][i] <= remi[i];
                        qt_reg[g][i]  <= {qi[i][NW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [31:0] uj, uk, oj, ok, ui;
                logic [31:0]        ua;
                logic signed [63:0] c;
                logic [30:0]        a1;
                ui = side_reg[S_U].dir[i];
                uj = side_reg[S_U].dir[(i + 1) % 3];
                uk = side_reg[S_U].dir[(i + 2) % 3];
                oj = side_reg[S_U].launch[(i + 1) % 3];
                ok = side_reg[S_U].launch[(i + 2) % 3];
                ua = ui[31] ? -ui : ui;
                pr_reg[i][0] <= uj * ok;
                pr_reg[i][1] <= uk * oj;
                usq_reg[i]   <= ua[30:0] * ua[30:0];
                c            = pr_reg[i][0] - pr_reg[i][1];
                ca_reg[i]    <= c[63] ? 64'(-c) : 64'(c);
                a1           = ca_reg[i][62:32];
                pll_reg[i]   <= ca_reg[i][31:0] * ca_reg[i][31:0];
                plm_reg[i]   <= ca_reg[i][31:0] * a1;
                phh_reg[i]   <= a1 * a1;
                csq_reg[i]   <= {2'd0, phh_reg[i], 64'd0} + {32'd0, plm_reg[i], 33'd0}
                                + {64'd0, pll_reg[i]};
            end
            uu_reg  <= 64'(usq_reg[0]) + 64'(usq_reg[1]) + 64'(usq_reg[2]);
            q00_reg <= r2_reg[31:0] * uu_reg[31:0];
            q01_reg <= r2_reg[31:0] * uu_reg[63:32];
            q10_reg <= r2_reg[61:32] * uu_reg[31:0];
            q11_reg <= r2_reg[61:32] * uu_reg[63:32];
            rhs_reg <= {2'd0, q11_reg, 64'd0}
                       + {31'd0, 65'(q01_reg) + 65'(q10_reg), 32'd0}
                       + {64'd0, q00_reg};
            hit_reg <= !side_reg[S_W].degen
                       && ((csq_reg[0] + csq_reg[1] + csq_reg[2]) <= rhs_reg);
        end
    end

endmodule

/* rtl/core/ray_generate_sphere_test_core.sv */
// Top level of the ray generate and bounding-sphere test core.
//
//  channel     | direction | handshake          | payload
//  ------------+-----------+--------------------+-----------------------------------------
//  s_axis      | in        | tvalid/tready      | tdata: pixel_u,pixel_v,aperture_u,aperture_v
//  m_axis      | out       | tvalid/tready      | tdata: dir xyz, launch xyz; tuser: hit,degen
//  apb         | in        | psel/penable       | six registers at 8*i, 64-bit data
//
//  One request per cycle sustained while m_axis_tready is high; 4 front stages, the queue
//  and 75 back stages (32 square-root and 31 division steps dominate).
//  rst_n clears all control state asynchronously; payload registers are not reset.
//  A stalled output freezes the back pipeline; the queue absorbs the front until it fills.
module ray_generate_sphere_test_core
#(
    parameter int COORD_WIDTH = rgst_pkg::COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgst_pkg::ADDR_W-1:0]     paddr,
    input  logic [rgst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgst_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [127:0]                    s_axis_tdata,  // pixel_u, pixel_v, aperture_u, aperture_v
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [191:0]                    m_axis_tdata,  // dir_x,y,z, launch_x,y,z
    output logic [1:0]                      m_axis_tuser   // hit, degenerate
);

    rgst_pkg::cfg_t  cfg;
    rgst_pkg::item_t f_item, q_head;
    logic            f_valid, q_not_full, q_not_empty, q_pop;

    rgst_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgst_front #(.COORD_WIDTH(COORD_WIDTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (q_not_full),
        .out_item  (f_item)
    );

    rgst_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && q_not_full),
        .push_item (f_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rgst_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .sphere_radius (cfg.sphere_radius),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* verif/tb_ray_generate_sphere_test_core.sv */
// Self-checking testbench for the ray generate and bounding-sphere test core.
`timescale 1ns / 100ps

module tb_ray_generate_sphere_test_core;

    typedef struct {
        logic [31:0] dir [3];
        logic [31:0] launch [3];
        logic        hit;
        logic        degen;
    } ray_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [rgst_pkg::ADDR_W-1:0]     paddr;
    logic [rgst_pkg::APB_DATA_W-1:0] pwdata;
    logic [rgst_pkg::APB_DATA_W-1:0] prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    logic [47:0]        bx_q, by_q, bz_q;
    logic signed [31:0] det_q, ap_q;
    logic [30:0]        rad_q;

    ray_t expected_rays [$];
    int   errors;
    int   cycles;
    int   stall_phase;

    localparam int LIMIT = 2000000;

    ray_generate_sphere_test_core dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint sq_root(longint unsigned x);
        longint unsigned res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x) one >>= 2;
        while (one != 0)
        begin
            if (x >= res + one)
            begin
                x = x - (res + one);
                res = (res >> 1) + one;
            end
            else
                res >>= 1;
            one >>= 2;
        end
        return res;
    endfunction

    function automatic ray_t trace_ray(logic [31:0] pu, logic [31:0] pv,
                                       logic [31:0] au, logic [31:0] av);
        ray_t r;
        longint base, tgt, l, cprod;
        longint o [3];
        longint d [3];
        longint u [3];
        logic [63:0] mag [3];
        logic [63:0] m, sum, norm, uu, q;
        logic [127:0] cr, rhs, r2;
        int j, k;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            base = longint'($signed(bz_q[16*i +: 16])) * longint'(det_q)
                 + longint'($signed(bx_q[16*i +: 16])) * longint'($signed(pu))
                 + longint'($signed(by_q[16*i +: 16])) * longint'($signed(pv));
            tgt = longint'($signed(bz_q[16*i +: 16])) * longint'(ap_q)
                + longint'($signed(bx_q[16*i +: 16])) * longint'($signed(au))
                + longint'($signed(by_q[16*i +: 16])) * longint'($signed(av));
            l = (base + 8192) >>> 14;
            if (l > 64'sd2147483647) l = 64'sd2147483647;
            if (l < -64'sd2147483648) l = -64'sd2147483648;
            o[i] = l;
            d[i] = tgt - base;
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            if (mag[i] > m) m = mag[i];
        end
        r.degen = (m == 0);
        r.hit = 1'b0;
        if (r.degen)
            for (int i = 0; i < 3; i++) u[i] = 0;
        else
        begin
            while (m >= 64'd1 << 31)
            begin
                m >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (m < 64'd1 << 30)
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            norm = sq_root(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << 30) + (norm >> 1)) / norm;
                u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            end
            cr = 0;
            uu = 0;
            for (int i = 0; i < 3; i++)
            begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                cprod = u[j] * o[k] - u[k] * o[j];
                if (cprod < 0) cprod = -cprod;
                cr += 128'(cprod) * 128'(cprod);
                uu += 64'(u[i] < 0 ? -u[i] : u[i]) ** 2;
            end
            r2 = 128'(rad_q) * 128'(rad_q);
            rhs = 128'(r2[63:0]) * 128'(uu);
            r.hit = (cr <= rhs);
        end
        for (int i = 0; i < 3; i++)
        begin
            r.dir[i] = u[i][31:0];
            r.launch[i] = o[i][31:0];
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        ray_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_rays.size() == 0)
            begin
                report("unexpected result", m_axis_tdata[31:0], '0);
            end
            else
            begin
                e = expected_rays.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (m_axis_tdata[32*i +: 32] !== e.dir[i])
                        report("dir", m_axis_tdata[32*i +: 32], e.dir[i]);
                    if (m_axis_tdata[96+32*i +: 32] !== e.launch[i])
                        report("launch", m_axis_tdata[96+32*i +: 32], e.launch[i]);
                end
                if (m_axis_tuser[0] !== e.hit) report("hit", m_axis_tuser[0], e.hit);
                if (m_axis_tuser[1] !== e.degen) report("degenerate", m_axis_tuser[1], e.degen);
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 300) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= stall_phase[2] ^ stall_phase[4];
            default: m_axis_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    task automatic write_reg(rgst_pkg::reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rgst_pkg::ADDR_W'(8 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rgst_pkg::REG_BASIS_X: bx_q = val[47:0];
            rgst_pkg::REG_BASIS_Y: by_q = val[47:0];
            rgst_pkg::REG_BASIS_Z: bz_q = val[47:0];
            rgst_pkg::REG_DET_OFS: det_q = val[31:0];
            rgst_pkg::REG_AP_OFS:  ap_q = val[31:0];
            default:               rad_q = val[30:0];
        endcase
    endtask

    task automatic send_ray(logic [31:0] pu, logic [31:0] pv,
                            logic [31:0] au, logic [31:0] av);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {av, au, pv, pu};
        do @(posedge clk); while (!s_axis_tready);
        expected_rays.push_back(trace_ray(pu, pv, au, av));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_rays.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'h4000;
            2: return 16'h0000;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // directed stimulus: pixel_u, pixel_v, aperture_u, aperture_v
    logic [31:0] directed [12][4] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0},
        '{32'h0, 32'h0, 32'h0001_0000, 32'h0},
        '{32'h0, 32'h0, 32'h0, 32'h0001_0000},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000},
        '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
        '{32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff},
        '{32'h0000_2000, 32'hffff_e000, 32'h0, 32'h0},
        '{32'h0, 32'h0, 32'h0000_0001, 32'h0},
        '{32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321},
        '{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0},
        '{32'hffff_0000, 32'h0002_0000, 32'h0005_0000, 32'hfff0_0000}
    };

    initial
    begin
        ray_t e;
        int burst;
        logic [31:0] pu, pv;
        errors = 0;
        cycles = 0;
        stall_phase = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        bx_q = 48'd16384;
        by_q = 48'd1073741824;
        bz_q = 48'd70368744177664;
        det_q = 0;
        ap_q = 0;
        rad_q = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset basis: degenerate all-zero ray, then a known axis ray
        send_ray(0, 0, 0, 0);
        e = expected_rays[$];
        e.dir = '{0, 0, 0};
        e.launch = '{0, 0, 0};
        e.hit = 1'b0;
        e.degen = 1'b1;
        expected_rays[$] = e;
        send_ray(0, 0, 32'h0001_0000, 0);
        e = expected_rays[$];
        e.dir = '{32'h4000_0000, 0, 0};
        e.launch = '{0, 0, 0};
        e.hit = 1'b1;
        e.degen = 1'b0;
        expected_rays[$] = e;
        foreach (directed[i])
            send_ray(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
        drain();

        write_reg(rgst_pkg::REG_DET_OFS, 64'h0000_0000_fff0_0000);
        write_reg(rgst_pkg::REG_AP_OFS, 64'h0000_0000_0010_0000);
        write_reg(rgst_pkg::REG_RADIUS, 64'h0000_0000_7fff_ffff);
        foreach (directed[i])
            send_ray(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
        drain();

        write_reg(rgst_pkg::REG_BASIS_X, 64'h8000_8000_8000);
        write_reg(rgst_pkg::REG_BASIS_Y, 64'h7fff_7fff_7fff);
        write_reg(rgst_pkg::REG_BASIS_Z, 64'hffff_ffff_ffff);
        write_reg(rgst_pkg::REG_DET_OFS, 64'h8000_0000);
        write_reg(rgst_pkg::REG_AP_OFS, 64'h7fff_ffff);
        write_reg(rgst_pkg::REG_RADIUS, 64'h0);
        foreach (directed[i])
            send_ray(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(rgst_pkg::REG_BASIS_X, {rand_lane(), rand_lane(), rand_lane()});
            write_reg(rgst_pkg::REG_BASIS_Y, {rand_lane(), rand_lane(), rand_lane()});
            write_reg(rgst_pkg::REG_BASIS_Z, {rand_lane(), rand_lane(), rand_lane()});
            write_reg(rgst_pkg::REG_DET_OFS, rand_coord());
            write_reg(rgst_pkg::REG_AP_OFS,
                      (phase % 3 == 0) ? 64'(det_q) : 64'(rand_coord()));
            write_reg(rgst_pkg::REG_RADIUS,
                      phase == 0 ? 64'h7fff_ffff : 64'($urandom_range(0, 32'h7fff_ffff) >>
                      $urandom_range(0, 30)));
            for (int n = 0; n < 200; )
            begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst; b++, n++)
                begin
                    pu = rand_coord();
                    pv = rand_coord();
                    if ($urandom_range(0, 9) == 0)
                        send_ray(pu, pv, pu, pv);
                    else
                        send_ray(pu, pv, rand_coord(), rand_coord());
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* ray_generate_sphere_test_core.f */
rtl/core/rgst_pkg.sv
rtl/core/rgst_regs.sv
rtl/core/rgst_front.sv
rtl/core/rgst_queue.sv
rtl/core/rgst_back.sv
rtl/core/ray_generate_sphere_test_core.sv
verif/tb_ray_generate_sphere_test_core.sv
